// ----- rtl/sdc_pkg.sv -----
// Shared types, codes and CRC helpers for the SD card SPI-mode target.
package sdc_pkg;

	localparam int SECTOR_BYTES = 512;
	localparam logic [3:0] WARMUP_BYTES = 4'd10;

	localparam logic REQ_READ  = 1'b0;
	localparam logic REQ_WRITE = 1'b1;

	localparam logic [1:0] ADDR_CTRL = 2'd0;
	localparam logic [1:0] ADDR_DATA = 2'd1;

	localparam logic [2:0] REG_PRESENT = 3'd0;
	localparam logic [2:0] REG_WPROT   = 3'd1;
	localparam logic [2:0] REG_BLKCNT  = 3'd2;
	localparam logic [2:0] REG_POLLS   = 3'd3;
	localparam logic [2:0] REG_RDELAY  = 3'd4;

	localparam logic [7:0] TOK_START   = 8'hFE;
	localparam logic [7:0] TOK_MSTART  = 8'hFC;
	localparam logic [7:0] TOK_MSTOP   = 8'hFD;
	localparam logic [7:0] CMD_STOP    = 8'h4C;
	localparam logic [7:0] R1_READY    = 8'h00;
	localparam logic [7:0] R1_IDLE     = 8'h01;
	localparam logic [7:0] R1_ILLEGAL  = 8'h04;
	localparam logic [7:0] R1_ILL_IDLE = 8'h05;
	localparam logic [7:0] R1_CRCERR   = 8'h09;
	localparam logic [7:0] R1_PARAM    = 8'h40;
	localparam logic [7:0] DR_ACCEPT   = 8'h05;
	localparam logic [7:0] DR_CRCERR   = 8'h0B;
	localparam logic [31:0] OCR_VALUE  = 32'hC0FF8000;

	typedef enum logic [3:0] {
		PH_IDLE, PH_CMD, PH_WAIT, PH_RESP, PH_RPEND, PH_RDELAY, PH_RTOKEN,
		PH_RBLOCK, PH_RCRC, PH_WTOKEN, PH_WBLOCK, PH_WCRC, PH_WBUSY
	} sdc_phase_t;

	typedef enum logic [2:0] {
		CS_CLEAR, CS_IDLE, CS_FETCH, CS_EXEC, CS_COPY
	} sdc_cstate_t;

	typedef struct packed {
		logic load;
		logic fetch;
		logic exec;
		logic clr;
		logic copy;
	} sdc_cmd_t;

	typedef struct packed {
		logic sweep_last;
		logic commit;
	} sdc_sts_t;

	function automatic logic [7:0] crc7_byte(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int i = 0; i < 8; i++) begin
			if (c[7]) c = c ^ 8'h89;
			c = {c[6:0], 1'b0};
		end
		return c;
	endfunction

	function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			if (c[15]) c = {c[14:0], 1'b0} ^ 16'h1021;
			else c = {c[14:0], 1'b0};
		end
		return c;
	endfunction

endpackage

// ----- rtl/sdc_ctrl.sv -----
// Item sequencer: clearing pass, accept, memory fetch, execute, sector copy.
module sdc_ctrl
	import sdc_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  logic     out_free,
	input  sdc_sts_t sts,
	output sdc_cmd_t cmd
);

	sdc_cstate_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= CS_CLEAR;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			CS_CLEAR: if (sts.sweep_last) state_d = CS_IDLE;
			CS_IDLE:  if (in_valid) state_d = CS_FETCH;
			CS_FETCH: state_d = CS_EXEC;
			CS_EXEC: begin
				if (out_free) state_d = sts.commit ? CS_COPY : CS_IDLE;
			end
			CS_COPY:  if (sts.sweep_last) state_d = CS_IDLE;
			default:  state_d = CS_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		case (state_q)
			CS_CLEAR: cmd.clr = 1'b1;
			CS_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			CS_FETCH: cmd.fetch = 1'b1;
			CS_EXEC:  cmd.exec = out_free;
			CS_COPY:  cmd.copy = 1'b1;
			default: ;
		endcase
	end

endmodule

// ----- rtl/sdc_dp.sv -----
// Card datapath: protocol state, command parser, block buffer and sector store.
module sdc_dp
	import sdc_pkg::*;
#(
	parameter int SECTORS = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  sdc_cmd_t   cmd,
	output sdc_sts_t   sts,
	input  logic       req_type,
	input  logic [1:0] addr,
	input  logic [7:0] wdata,
	input  logic       card_present,
	input  logic       write_protect,
	input  logic [6:0] block_count,
	input  logic [2:0] acmd41_busy_polls,
	input  logic [4:0] read_delay,
	output logic [7:0] rdata
);

	localparam int DEPTH = SECTORS * SECTOR_BYTES;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = $clog2(SECTORS + 1);
	localparam int EW    = (CW > 7) ? CW : 7;
	localparam int SWW   = (AW > 10) ? AW : 10;

	logic [7:0] store_mem [DEPTH];
	logic [7:0] buf_mem [SECTOR_BYTES];
	logic [7:0] st_rd_q, buf_rd_q;
	logic [SWW-1:0] sw_q;

	logic       req_q;
	logic [1:0] addr_q;
	logic [7:0] wd_q;

	sdc_phase_t phase_q, phase_d;
	logic cs_q, cs_d;
	logic [47:0] cmd_q, cmd_d;
	logic [2:0] cnt_q, cnt_d;
	logic [7:0] crc7_q, crc7_d;
	logic [39:0] resp_q, resp_d;
	logic [2:0] rlen_q, rlen_d, rpos_q, rpos_d;
	logic [9:0] bpos_q, bpos_d;
	logic [CW-1:0] sector_q, sector_d;
	logic hc_q, hc_d, app_q, app_d, init_q, init_d, crcen_q, crcen_d;
	logic rmulti_q, rmulti_d, wmulti_q, wmulti_d, data_q, data_d;
	logic [7:0] status_q, status_d;
	logic [3:0] warm_q, warm_d;
	logic [2:0] polls_q, polls_d, busy_q, busy_d;
	logic [4:0] delay_q, delay_d;
	logic [15:0] crc_q, crc_d, crcrx_q, crcrx_d;
	logic [7:0] miso_q, miso_d;

	logic [EW-1:0] eff;
	logic [CW-1:0] sec_inc;
	logic [AW-1:0] rd_addr, wr_addr;
	logic [SWW-1:0] sw_m1;
	logic buf_we, commit;

	assign eff = (EW'(block_count) > EW'(SECTORS)) ? EW'(SECTORS) : EW'(block_count);
	assign sec_inc = sector_q + 1'b1;
	assign rd_addr = AW'({sector_q, bpos_q[8:0]});
	assign sw_m1 = sw_q - 1'b1;
	assign wr_addr = cmd.clr ? AW'(sw_q) : AW'({sector_q, sw_m1[8:0]});

	assign sts.sweep_last = cmd.clr ? (sw_q == SWW'(DEPTH - 1)) : (sw_q == SWW'(SECTOR_BYTES));
	assign sts.commit = commit;

	// sweep counter, shared by the clearing pass and the buffer-to-store copy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) sw_q <= '0;
		else if (cmd.clr || cmd.copy) sw_q <= sw_q + 1'b1;
		else sw_q <= '0;
	end

	always_ff @(posedge clk) begin
		if (cmd.clr) store_mem[wr_addr] <= 8'hFF;
		else if (cmd.copy && sw_q != '0) store_mem[wr_addr] <= buf_rd_q;
		if (cmd.fetch) st_rd_q <= store_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (buf_we) buf_mem[bpos_q[8:0]] <= wd_q;
		if (cmd.copy) buf_rd_q <= buf_mem[sw_q[8:0]];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q  <= req_type;
			addr_q <= addr;
			wd_q   <= wdata;
		end
	end

	always_comb begin
		logic [47:0] cmd_new;
		logic [5:0]  c;
		logic [31:0] arg, lba;
		logic [7:0]  miso, q_r1, r1_idle;
		logic [31:0] q_extra;
		logic [2:0]  q_len, k;
		logic        do_q;
		logic [15:0] rx;

		phase_d = phase_q; cs_d = cs_q; cmd_d = cmd_q; cnt_d = cnt_q; crc7_d = crc7_q;
		resp_d = resp_q; rlen_d = rlen_q; rpos_d = rpos_q; bpos_d = bpos_q;
		sector_d = sector_q; hc_d = hc_q; app_d = app_q; init_d = init_q;
		crcen_d = crcen_q; rmulti_d = rmulti_q; wmulti_d = wmulti_q; data_d = data_q;
		status_d = status_q; warm_d = warm_q; polls_d = polls_q; busy_d = busy_q;
		delay_d = delay_q; crc_d = crc_q; crcrx_d = crcrx_q; miso_d = miso_q;
		rdata = 8'h00; buf_we = 1'b0; commit = 1'b0;
		miso = 8'hFF; q_r1 = 8'h00; q_extra = 32'h0; q_len = 3'd1; do_q = 1'b0;
		r1_idle = init_q ? R1_READY : R1_IDLE;
		k = cnt_q % 3'd6;
		cmd_new = cmd_q;
		for (int i = 0; i < 6; i++) begin
			if (k == 3'(i)) cmd_new[47 - 8*i -: 8] = wd_q;
		end
		c = cmd_new[45:40];
		arg = cmd_new[39:8];
		lba = hc_q ? arg : {9'b0, arg[31:9]};
		rx = {crcrx_q[15:8], wd_q};

		if (req_q == REQ_WRITE) begin
			if (addr_q == ADDR_CTRL) begin
				cs_d = wd_q[0];
				if (!wd_q[0]) begin
					phase_d = PH_IDLE;
					cnt_d = 3'd0;
					rlen_d = 3'd0;
					rpos_d = 3'd0;
					data_d = 1'b0;
				end
			end else if (addr_q == ADDR_DATA) begin
				if (!card_present) begin
					miso = 8'hFF;
				end else if (!cs_q) begin
					if (!init_q && warm_q < WARMUP_BYTES) warm_d = warm_q + 1'b1;
				end else if ((phase_q == PH_RPEND || phase_q == PH_RDELAY ||
						phase_q == PH_RTOKEN || phase_q == PH_RBLOCK ||
						phase_q == PH_RCRC) && rmulti_q && wd_q == CMD_STOP) begin
					rmulti_d = 1'b0;
					cmd_d = {wd_q, 40'h0};
					cnt_d = 3'd1;
					crc7_d = crc7_byte(8'h00, wd_q);
					phase_d = PH_CMD;
				end else begin
					case (phase_q)
						PH_IDLE: begin
							if (wd_q[7:6] == 2'b01 && (init_q || warm_q >= WARMUP_BYTES)) begin
								cmd_d = {wd_q, 40'h0};
								cnt_d = 3'd1;
								crc7_d = crc7_byte(8'h00, wd_q);
								phase_d = PH_CMD;
							end
						end
						PH_CMD: begin
							cmd_d = cmd_new;
							cnt_d = cnt_q + 1'b1;
							if (cnt_q <= 3'd4) crc7_d = crc7_byte(crc7_q, wd_q);
							if (cnt_q + 1'b1 >= 3'd6) begin
								cnt_d = 3'd0;
								data_d = 1'b0;
								do_q = 1'b1;
								if ((c == 6'd0 || c == 6'd8) && wd_q != (crc7_q | 8'h01)) begin
									q_r1 = R1_CRCERR;
								end else if (app_q) begin
									app_d = 1'b0;
									if (c != 6'd41) q_r1 = R1_ILLEGAL;
									else if (polls_q < acmd41_busy_polls) begin
										polls_d = polls_q + 1'b1;
										q_r1 = R1_IDLE;
									end else begin
										hc_d = arg[30];
										init_d = 1'b1;
										q_r1 = R1_READY;
									end
								end else begin
									case (c)
										6'd0: begin
											q_r1 = R1_IDLE;
											init_d = 1'b0;
											polls_d = 3'd0;
										end
										6'd8: begin
											q_r1 = R1_IDLE;
											q_len = 3'd5;
											q_extra = {20'h0, arg[11:0]};
										end
										6'd12: begin
											rmulti_d = 1'b0;
											q_r1 = R1_READY;
										end
										6'd13: begin
											q_r1 = r1_idle;
											q_len = 3'd2;
											q_extra = {status_q, 24'h0};
										end
										6'd16: q_r1 = r1_idle;
										6'd17, 6'd18, 6'd24, 6'd25: begin
											if (!init_q) q_r1 = R1_ILL_IDLE;
											else if (lba >= 32'(eff)) begin
												status_d = status_q | R1_PARAM;
												q_r1 = R1_PARAM;
											end else begin
												sector_d = CW'(lba);
												if (c == 6'd17) rmulti_d = 1'b0;
												if (c == 6'd18) rmulti_d = 1'b1;
												if (c == 6'd24) wmulti_d = 1'b0;
												if (c == 6'd25) wmulti_d = 1'b1;
												q_r1 = R1_READY;
												data_d = 1'b1;
											end
										end
										6'd55: begin
											q_r1 = r1_idle;
											app_d = 1'b1;
										end
										6'd58: begin
											q_r1 = r1_idle;
											q_len = 3'd5;
											q_extra = OCR_VALUE;
										end
										6'd59: begin
											crcen_d = arg[0];
											q_r1 = r1_idle;
										end
										default: q_r1 = init_q ? R1_ILLEGAL : R1_ILL_IDLE;
									endcase
								end
							end
						end
						PH_WAIT: phase_d = PH_RESP;
						PH_RESP: begin
							if (rpos_q < rlen_q && rpos_q < 3'd5) begin
								for (int i = 0; i < 5; i++) begin
									if (rpos_q == 3'(i)) miso = resp_q[39 - 8*i -: 8];
								end
								rpos_d = rpos_q + 1'b1;
								if (rpos_q + 1'b1 == rlen_q) begin
									if (data_q)
										phase_d = (cmd_q[45:40] == 6'd17 || cmd_q[45:40] == 6'd18)
											? PH_RPEND : PH_WTOKEN;
									else
										phase_d = PH_IDLE;
									data_d = 1'b0;
								end
							end else begin
								phase_d = PH_IDLE;
								status_d = 8'h00;
							end
						end
						PH_RPEND: begin
							delay_d = read_delay;
							phase_d = PH_RDELAY;
						end
						PH_RDELAY: begin
							if (delay_q != 5'd0) delay_d = delay_q - 1'b1;
							else phase_d = PH_RTOKEN;
						end
						PH_RTOKEN: begin
							miso = TOK_START;
							bpos_d = 10'd0;
							crc_d = 16'h0;
							phase_d = PH_RBLOCK;
						end
						PH_RBLOCK: begin
							miso = st_rd_q;
							crc_d = crc16_byte(crc_q, st_rd_q);
							bpos_d = bpos_q + 1'b1;
							if (bpos_q == 10'(SECTOR_BYTES - 1)) begin
								bpos_d = 10'd0;
								phase_d = PH_RCRC;
							end
						end
						PH_RCRC: begin
							miso = (bpos_q == 10'd0) ? crc_q[15:8] : crc_q[7:0];
							bpos_d = bpos_q + 1'b1;
							if (bpos_q != 10'd0) begin
								bpos_d = 10'd0;
								phase_d = PH_IDLE;
								if (rmulti_q) begin
									sector_d = sec_inc;
									if (EW'(sec_inc) >= eff) rmulti_d = 1'b0;
									else phase_d = PH_RPEND;
								end
							end
						end
						PH_WTOKEN: begin
							if (wd_q == TOK_START || (wmulti_q && wd_q == TOK_MSTART)) begin
								bpos_d = 10'd0;
								crc_d = 16'h0;
								phase_d = PH_WBLOCK;
							end else if (wmulti_q && wd_q == TOK_MSTOP) begin
								wmulti_d = 1'b0;
								busy_d = 3'd5;
								phase_d = PH_WBUSY;
							end else if (wd_q[7:4] != 4'hF) begin
								phase_d = PH_IDLE;
							end
						end
						PH_WBLOCK: begin
							buf_we = cmd.exec;
							crc_d = crc16_byte(crc_q, wd_q);
							bpos_d = bpos_q + 1'b1;
							if (bpos_q == 10'(SECTOR_BYTES - 1)) begin
								bpos_d = 10'd0;
								phase_d = PH_WCRC;
							end
						end
						PH_WCRC: begin
							if (bpos_q == 10'd0) begin
								crcrx_d = {wd_q, 8'h00};
								bpos_d = 10'd1;
							end else begin
								crcrx_d = rx;
								bpos_d = 10'd0;
								if (crcen_q && rx != crc_q) begin
									miso = DR_CRCERR;
									phase_d = PH_IDLE;
								end else begin
									commit = !write_protect && (EW'(sector_q) < eff);
									miso = DR_ACCEPT;
									busy_d = 3'd5;
									phase_d = PH_WBUSY;
								end
							end
						end
						PH_WBUSY: begin
							miso = 8'h00;
							if (busy_q != 3'd0) busy_d = busy_q - 1'b1;
							else begin
								miso = 8'hFF;
								phase_d = wmulti_q ? PH_WTOKEN : PH_IDLE;
							end
						end
						default: phase_d = PH_IDLE;
					endcase
				end
				if (do_q) begin
					resp_d = {q_r1, q_extra};
					rlen_d = q_len;
					rpos_d = 3'd0;
					phase_d = PH_WAIT;
				end
				miso_d = miso;
			end
		end else begin
			if (addr_q == ADDR_CTRL) rdata = {7'b0, card_present};
			else if (addr_q == ADDR_DATA) rdata = miso_q;
			else rdata = 8'hFF;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE; cs_q <= 1'b0; cmd_q <= '0; cnt_q <= '0; crc7_q <= '0;
			resp_q <= '0; rlen_q <= '0; rpos_q <= '0; bpos_q <= '0; sector_q <= '0;
			hc_q <= 1'b1; app_q <= 1'b0; init_q <= 1'b0; crcen_q <= 1'b0;
			rmulti_q <= 1'b0; wmulti_q <= 1'b0; data_q <= 1'b0; status_q <= '0;
			warm_q <= '0; polls_q <= '0; busy_q <= '0; delay_q <= '0;
			crc_q <= '0; crcrx_q <= '0; miso_q <= 8'hFF;
		end else if (cmd.exec) begin
			phase_q <= phase_d; cs_q <= cs_d; cmd_q <= cmd_d; cnt_q <= cnt_d;
			crc7_q <= crc7_d; resp_q <= resp_d; rlen_q <= rlen_d; rpos_q <= rpos_d;
			bpos_q <= bpos_d; sector_q <= sector_d; hc_q <= hc_d; app_q <= app_d;
			init_q <= init_d; crcen_q <= crcen_d; rmulti_q <= rmulti_d;
			wmulti_q <= wmulti_d; data_q <= data_d; status_q <= status_d;
			warm_q <= warm_d; polls_q <= polls_d; busy_q <= busy_d; delay_q <= delay_d;
			crc_q <= crc_d; crcrx_q <= crcrx_d; miso_q <= miso_d;
		end
	end

endmodule

// ----- rtl/sd_card_spi_mode_target.sv -----
// Each bus access passes through accept, sector store read and execute; execute waits until the output is free.
// A data block that is accepted into the store adds a copy from the block buffer,
// during which no access is taken. Output is held in a register: one transfer waits there
// while the next access is accepted. After reset a clearing pass writes 0xFF to all
// SECTORS*512 store bytes, one per cycle, before the first access; config writes go any time.
module sd_card_spi_mode_target
	import sdc_pkg::*;
#(
	parameter int SECTORS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // wdata
	input  logic [2:0]  s_axis_tuser,  // addr[1:0], req_type
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,  // rdata
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic       present_q, wprot_q;
	logic [6:0] blkcnt_q;
	logic [2:0] polls_q;
	logic [4:0] rdelay_q;
	logic       m_valid_q;
	logic [7:0] m_data_q;
	logic       out_free;
	logic [7:0] rdata;
	sdc_cmd_t   cmd;
	sdc_sts_t   sts;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q <= 1'b1;
			wprot_q   <= 1'b0;
			blkcnt_q  <= 7'd64;
			polls_q   <= 3'd1;
			rdelay_q  <= 5'd0;
		end else if (psel && penable && pwrite && pready) begin
			case (paddr[4:2])
				REG_PRESENT: present_q <= pwdata[0];
				REG_WPROT:   wprot_q   <= pwdata[0];
				REG_BLKCNT:  blkcnt_q  <= pwdata[6:0];
				REG_POLLS:   polls_q   <= pwdata[2:0];
				REG_RDELAY:  rdelay_q  <= pwdata[4:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:2])
			REG_PRESENT: prdata = {31'b0, present_q};
			REG_WPROT:   prdata = {31'b0, wprot_q};
			REG_BLKCNT:  prdata = {25'b0, blkcnt_q};
			REG_POLLS:   prdata = {29'b0, polls_q};
			REG_RDELAY:  prdata = {27'b0, rdelay_q};
			default:     prdata = 32'h0;
		endcase
	end

	assign out_free = !m_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) m_valid_q <= 1'b0;
		else if (cmd.exec) m_valid_q <= 1'b1;
		else if (m_axis_tready) m_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) m_data_q <= rdata;
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

	sdc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.out_free (out_free),
		.sts      (sts),
		.cmd      (cmd)
	);

	sdc_dp #(.SECTORS(SECTORS)) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.sts               (sts),
		.req_type          (s_axis_tuser[0]),
		.addr              (s_axis_tuser[2:1]),
		.wdata             (s_axis_tdata),
		.card_present      (present_q),
		.write_protect     (wprot_q),
		.block_count       (blkcnt_q),
		.acmd41_busy_polls (polls_q),
		.read_delay        (rdelay_q),
		.rdata             (rdata)
	);

endmodule
